// ===== rtl/hpe_pkg.sv =====
package hpe_pkg;

    localparam int MAX_DEGREE_DEF = 15;

    localparam int DATA_W  = 32;
    localparam int DEG_W   = 4;
    localparam int IDX_W   = 4;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SHIFT_W = PROD_W - FRAC_W;
    localparam int SUM_W   = SHIFT_W + 1;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic start;
        logic mul_en;
        logic add_en;
    } t_step_ctrl;

endpackage

// ===== rtl/horner_polynomial_eval.sv =====
// Horner polynomial evaluator in signed Q16.16. A load transaction writes one
// coefficient into the store, which reads as zero after reset, and leaves the
// input ready. An evaluate transaction runs a multiply step and an add-and-
// saturate step per coefficient through a single 32 by 32 multiplier and a
// store with a registered read port, and holds the input until its result
// enters the output register; the input is taken again while that result waits,
// and a second result waits in the engine until the first one has gone. Degrees
// above MAX_DEGREE use MAX_DEGREE, and loads to an index above MAX_DEGREE are
// dropped.
module horner_polynomial_eval #(
    parameter int MAX_DEGREE = hpe_pkg::MAX_DEGREE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hpe_pkg::DEG_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // coeff_index [3:0], coeff_value [35:4], point_x [67:36], zero fill.
    input  logic [hpe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // operation [0].
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // poly_value [31:0].
    output logic [hpe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // overflow [0].
    output logic [0:0]                      m_axis_tuser
);
    import hpe_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [AW-1:0]           r_idx;
    logic [AW-1:0]           n_idx;
    logic [DEG_W-1:0]        r_degree;
    logic                    r_out_valid;
    logic [DATA_W-1:0]       r_out_data;
    logic                    r_out_ovf;

    logic                    w_in_acc;
    logic                    w_op;
    logic [IDX_W-1:0]        w_cidx;
    logic [DATA_W-1:0]       w_cval;
    logic [DATA_W-1:0]       w_px;
    logic [AW-1:0]           w_top;
    logic                    w_we;
    logic                    w_re;
    logic [AW-1:0]           w_raddr;
    logic [DATA_W-1:0]       w_rdata;
    logic                    w_out_free;
    logic                    w_out_load;
    t_step_ctrl              w_ctrl;
    logic signed [DATA_W-1:0] w_acc;
    logic                    w_ovf;

    assign w_op   = s_axis_tuser[0];
    assign w_cidx = s_axis_tdata[IDX_W-1:0];
    assign w_cval = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];
    assign w_px   = s_axis_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_top         = (32'(r_degree) > MAX_DEGREE) ? AW'(MAX_DEGREE) : AW'(r_degree);
    assign w_we          = w_in_acc && (w_op == OP_LOAD) && (32'(w_cidx) <= MAX_DEGREE);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_out_load    = (r_state == S_DONE) && w_out_free;

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        w_re           = 1'b0;
        w_raddr        = w_top;
        w_ctrl.start   = 1'b0;
        w_ctrl.mul_en  = 1'b0;
        w_ctrl.add_en  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (w_op == OP_EVAL)) begin
                    w_re         = 1'b1;
                    w_raddr      = w_top;
                    w_ctrl.start = 1'b1;
                    n_idx        = w_top;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                w_ctrl.mul_en = 1'b1;
                n_state       = S_ADD;
            end
            S_ADD: begin
                w_ctrl.add_en = 1'b1;
                if (r_idx == '0) begin
                    n_state = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx - 1'b1;
                    n_idx   = r_idx - 1'b1;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_degree <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_degree <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_acc;
            r_out_ovf  <= w_ovf;
        end
    end

    hpe_coef_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (AW'(w_cidx)),
        .i_wdata (w_cval),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hpe_step u_step (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_x    ($signed(w_px)),
        .i_coef ($signed(w_rdata)),
        .o_acc  (w_acc),
        .o_ovf  (w_ovf)
    );

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_ovf;

endmodule

// ===== rtl/hpe_coef_mem.sv =====
module hpe_coef_mem #(
    parameter int DEPTH = hpe_pkg::MAX_DEGREE_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [hpe_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [hpe_pkg::DATA_W-1:0] o_rdata
);
    import hpe_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rdata;

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hpe_step.sv =====
module hpe_step (
    input  logic                              i_clk,
    input  hpe_pkg::t_step_ctrl               i_ctrl,
    input  logic signed [hpe_pkg::DATA_W-1:0] i_x,
    input  logic signed [hpe_pkg::DATA_W-1:0] i_coef,
    output logic signed [hpe_pkg::DATA_W-1:0] o_acc,
    output logic                              o_ovf
);
    import hpe_pkg::*;

    logic signed [DATA_W-1:0]  r_x;
    logic signed [DATA_W-1:0]  r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_ovf;
    logic signed [SHIFT_W-1:0] w_shift;
    logic signed [SUM_W-1:0]   w_sum;
    logic                      w_pos_ovf;
    logic                      w_neg_ovf;
    logic signed [DATA_W-1:0]  n_acc;

    always_comb begin
        w_shift   = $signed(r_prod[PROD_W-1:FRAC_W]);
        w_sum     = SUM_W'(w_shift) + SUM_W'(i_coef);
        w_pos_ovf = !w_sum[SUM_W-1] && (|w_sum[SUM_W-2:DATA_W-1]);
        w_neg_ovf = w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:DATA_W-1]);
        if (w_pos_ovf) begin
            n_acc = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_neg_ovf) begin
            n_acc = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_acc = w_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_x   <= i_x;
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (i_ctrl.add_en) begin
            r_acc <= n_acc;
            r_ovf <= r_ovf | w_pos_ovf | w_neg_ovf;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= r_acc * r_x;
        end
    end

    assign o_acc = r_acc;
    assign o_ovf = r_ovf;

endmodule

// ===== rtl/hpe_checker.sv =====
module hpe_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [0:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [hpe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                      m_axis_tuser
);
    import hpe_pkg::*;

    // An evaluation holds the input until its last step is done.
    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_EVAL)) |=> !s_axis_tready)
        else $error("input still ready after an evaluate transaction");

    // A load does not hold the input.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_LOAD)) |=> s_axis_tready)
        else $error("input not ready after a load transaction");

    // A new result only appears at the end of an evaluation.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an evaluation in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind horner_polynomial_eval hpe_checker u_hpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hpe_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN = -64'sh0000_0000_8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef struct {
        logic [31:0] value;
        logic        ovf;
    } t_poly_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [DEG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    logic signed [31:0] coeff_store [0:15];
    int                 cur_degree = 0;
    t_poly_result       pending_results [$];
    bit                 no_idle = 1'b0;
    int                 err_count = 0;
    int                 n_loads = 0;
    int                 n_evals = 0;
    int                 n_checked = 0;

    horner_polynomial_eval dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_poly_result horner_eval(logic signed [31:0] x);
        t_poly_result r;
        longint acc;
        longint prod;
        longint sum;
        acc = 0;
        r.ovf = 1'b0;
        for (int i = cur_degree; i >= 0; i--) begin
            prod = acc * longint'(x);
            sum = (prod >>> 16) + longint'(coeff_store[i]);
            if (sum > Q_MAX) begin
                sum = Q_MAX;
                r.ovf = 1'b1;
            end else if (sum < Q_MIN) begin
                sum = Q_MIN;
                r.ovf = 1'b1;
            end
            acc = sum;
        end
        r.value = acc[31:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_q16(bit tight);
        int v;
        if (tight) begin
            v = $urandom_range(0, 32'h0004_0000);
            return v - 32'h0002_0000;
        end
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: begin
                case ($urandom_range(0, 2))
                    0: return 32'h0;
                    1: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default: begin
                v = $urandom_range(0, 32'h0008_0000);
                return v - 32'h0004_0000;
            end
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [3:0] idx,
                             input logic [31:0] val, input logic [31:0] x);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, x, val, idx};
        s_axis_tuser  <= op;
        if (op == OP_EVAL) begin
            pending_results.push_back(horner_eval(x));
            n_evals++;
        end else begin
            coeff_store[idx] = val;
            n_loads++;
        end
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic load_coeff(input logic [3:0] idx, input logic [31:0] val);
        send_item(OP_LOAD, idx, val, $urandom);
    endtask

    task automatic eval_at(input logic [31:0] x);
        send_item(OP_EVAL, 4'($urandom), $urandom, x);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_degree(input int d);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= DEG_W'(d);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_degree = d;
    endtask

    // The store reads as zero after reset, at the reset degree and at the top degree.
    task automatic test_reset_store();
        eval_at(32'h7FFF_FFFF);
        set_degree(15);
        eval_at(32'h8000_0000);
        eval_at($urandom);
    endtask

    task automatic test_extremes();
        load_coeff(4'd15, 32'h7FFF_FFFF);
        load_coeff(4'd0, 32'h8000_0000);
        eval_at(32'h0);
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h8000_0000);
        eval_at(Q_ONE);
        eval_at(-Q_ONE);
        load_coeff(4'd15, 32'h8000_0000);
        load_coeff(4'd0, 32'h7FFF_FFFF);
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h0000_0001);
        send_item(OP_EVAL, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 4'd7, 32'h0, 32'hFFFF_FFFF);
    endtask

    // Negative products must be shifted towards minus infinity.
    task automatic test_floor_rounding();
        set_degree(1);
        load_coeff(4'd1, 32'hFFFF_FFFF);
        load_coeff(4'd0, 32'h0);
        eval_at(32'h0000_0001);
        eval_at(32'h0000_0003);
        eval_at(32'h8000_0000);
        load_coeff(4'd1, 32'h0001_8000);
        load_coeff(4'd0, 32'hFFFF_0000);
        eval_at(32'hFFFF_7FFF);
        eval_at(32'h0000_7FFF);
    endtask

    task automatic run_random_phase(input int deg, input int n_items, input bit tight);
        logic [3:0] idx;
        set_degree(deg);
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2)
                wait_idle();
            if ($urandom_range(0, 99) < 40) begin
                if ($urandom_range(0, 9) < 8)
                    idx = 4'($urandom_range(0, deg));
                else
                    idx = 4'($urandom);
                load_coeff(idx, ($urandom_range(0, 3) == 0) ? pick_q16(1'b0) : pick_q16(tight));
            end else begin
                eval_at(($urandom_range(0, 3) == 0) ? pick_q16(1'b0) : pick_q16(tight));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(15, 90, 1'b0);
        run_random_phase(0, 50, 1'b0);
        run_random_phase($urandom_range(1, 14), 90, 1'b1);
        no_idle = 1'b1;
        run_random_phase(3, 90, 1'b1);
        no_idle = 1'b0;
        run_random_phase(15, 90, 1'b1);
        run_random_phase($urandom_range(2, 8), 60, 1'b0);
        run_random_phase(15, 60, 1'b0);
    endtask

    initial begin
        t_poly_result exp_r;
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            n_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual value %h overflow %b",
                         $time, m_axis_tdata, m_axis_tuser[0]);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata !== exp_r.value) begin
                    $display("%0t: poly_value mismatch, expected %h, actual %h",
                             $time, exp_r.value, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tuser[0] !== exp_r.ovf) begin
                    $display("%0t: overflow mismatch, expected %b, actual %b",
                             $time, exp_r.ovf, m_axis_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("horner_polynomial_eval regression: fail");
        $finish;
    end

    initial begin
        for (int i = 0; i < 16; i++)
            coeff_store[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_store();
        test_extremes();
        test_floor_rounding();
        test_random_traffic();
        wait_idle();
        $display("Checked %0d results from %0d evaluations and %0d coefficient loads,",
                 n_checked, n_evals, n_loads);
        $display("at degrees 0 to 15, with random stalls on both sides and one stall-free run.");
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("horner_polynomial_eval regression: pass");
        end else begin
            $display("horner_polynomial_eval regression: fail");
        end
        $finish;
    end

endmodule
